/* hw/rtl/affine_background_pixel_fetch_defines.svh */
// assertion macros included by abg_fifo
`ifndef AFFINE_BACKGROUND_PIXEL_FETCH_DEFINES_SVH
`define AFFINE_BACKGROUND_PIXEL_FETCH_DEFINES_SVH

// condition holds at every edge out of reset
`define ABG_CHECK(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ABG_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ABG_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/abg_pkg.sv */
// ----------------------------------------------------------------------------
// abg_pkg
// types and constants of the affine background pixel fetch block
// ----------------------------------------------------------------------------
`default_nettype none

package abg_pkg;

    typedef enum logic [2:0] {
        KIND_PIXEL     = 3'd0,
        KIND_LINE_END  = 3'd1,
        KIND_LOAD_REF  = 3'd2,
        KIND_MEM_WRITE = 3'd3,
        KIND_PAL_WRITE = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_PIXEL  = 2'd1,
        OP_MEM_WR = 2'd2,
        OP_PAL_WR = 2'd3
    } op_t;

    localparam logic [1:0] MODE_MAP8   = 2'd0;
    localparam logic [1:0] MODE_MAP16  = 2'd1;
    localparam logic [1:0] MODE_BITMAP = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [2:0] CFG_CONTROL   = 3'd0;
    localparam logic [2:0] CFG_MAP_BASE  = 3'd1;
    localparam logic [2:0] CFG_TILE_BASE = 3'd2;
    localparam logic [2:0] CFG_PA        = 3'd3;
    localparam logic [2:0] CFG_PB        = 3'd4;
    localparam logic [2:0] CFG_PC        = 3'd5;
    localparam logic [2:0] CFG_PD        = 3'd6;

    // widest byte address the block supports
    localparam int ADDR_W = 20;

    typedef struct packed {
        logic [4:0]         control;
        logic [18:0]        map_base;
        logic [18:0]        tile_base;
        logic signed [15:0] pa;
        logic signed [15:0] pb;
        logic signed [15:0] pc;
        logic signed [15:0] pd;
    } abg_cfg_t;

    typedef struct packed {
        op_t               op;
        logic              clear;
        logic              bitmap;
        logic              map16;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        col;
        logic [2:0]        row;
        logic [7:0]        data;
        logic [15:0]       colour;
    } abg_item_t;

endpackage

`default_nettype wire

/* hw/rtl/affine_background_pixel_fetch.sv */
// Affine background pixel fetch. One transaction is accepted per clock while
// the output side keeps taking results; after its transaction leaves the
// four-entry queue, a pixel result passes in order through the registered map
// read, tile read and palette read stages of the two-bank video memory. Only pixel
// transactions produce a result. The video memory is split into even and
// odd byte banks of MEMORY_BYTES/2 bytes each.
// ----------------------------------------------------------------------------
// affine_background_pixel_fetch
// top level: configuration registers, front, queue and fetch pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module affine_background_pixel_fetch #(
    parameter int MEMORY_BYTES = 524288,
    parameter int COORD_BITS   = 28
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_write,
    input  wire  [2:0]         cfg_index,
    input  wire  [18:0]        cfg_data,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire  [2:0]         kind,
    input  wire  signed [27:0] start_x,
    input  wire  signed [27:0] start_y,
    input  wire  [18:0]        write_address,
    input  wire  [7:0]         write_byte,
    input  wire  [7:0]         palette_slot,
    input  wire  [15:0]        palette_colour,
    output logic               out_valid,
    input  wire                out_ready,
    output logic [15:0]        colour,
    output logic               transparent
);
    import abg_pkg::*;

    localparam int AW = $clog2(MEMORY_BYTES);
    localparam int IW = $bits(abg_item_t);

    abg_cfg_t  cfg_reg, cfg_next;
    abg_item_t push_item, head;
    logic      push, pop, q_full, q_empty;
    logic [IW-1:0] head_bits;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_CONTROL:   cfg_next.control   = cfg_data[4:0];
                CFG_MAP_BASE:  cfg_next.map_base  = cfg_data;
                CFG_TILE_BASE: cfg_next.tile_base = cfg_data;
                CFG_PA:        cfg_next.pa        = cfg_data[15:0];
                CFG_PB:        cfg_next.pb        = cfg_data[15:0];
                CFG_PC:        cfg_next.pc        = cfg_data[15:0];
                CFG_PD:        cfg_next.pd        = cfg_data[15:0];
                default:       cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.control   <= '0;
            cfg_reg.map_base  <= '0;
            cfg_reg.tile_base <= '0;
            cfg_reg.pa        <= 16'sd256;
            cfg_reg.pb        <= '0;
            cfg_reg.pc        <= '0;
            cfg_reg.pd        <= 16'sd256;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    abg_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .start_x        (start_x),
        .start_y        (start_y),
        .write_address  (write_address),
        .write_byte     (write_byte),
        .palette_slot   (palette_slot),
        .palette_colour (palette_colour),
        .q_full         (q_full),
        .push           (push),
        .push_item      (push_item)
    );

    abg_fifo #(
        .WIDTH(IW),
        .DEPTH(4)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_item),
        .pop       (pop),
        .pop_data  (head_bits),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign head = head_bits;

    abg_back #(
        .AW(AW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .tile_base   (cfg_reg.tile_base),
        .q_empty     (q_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .colour      (colour),
        .transparent (transparent)
    );

endmodule

`default_nettype wire

/* hw/rtl/abg_front.sv */
// ----------------------------------------------------------------------------
// abg_front
// accepts transactions, steps the affine points and classifies each pixel
// ----------------------------------------------------------------------------
`default_nettype none

module abg_front #(
    parameter int COORD_BITS = 28
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  abg_pkg::abg_cfg_t   cfg,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire  [2:0]          kind,
    input  wire  signed [27:0]  start_x,
    input  wire  signed [27:0]  start_y,
    input  wire  [18:0]         write_address,
    input  wire  [7:0]          write_byte,
    input  wire  [7:0]          palette_slot,
    input  wire  [15:0]         palette_colour,
    input  wire                 q_full,
    output logic                push,
    output abg_pkg::abg_item_t  push_item
);
    import abg_pkg::*;

    localparam int SXW = COORD_BITS - 8;

    logic [COORD_BITS-1:0] ref_x_reg, ref_x_next;
    logic [COORD_BITS-1:0] ref_y_reg, ref_y_next;
    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;

    logic            accept;
    logic [SXW-1:0]  sx, sy;
    logic [1:0]      mode;
    logic [1:0]      size;
    logic            wrap;
    logic [3:0]      wl, hl;
    logic [9:0]      mask_w, mask_h, x, y;
    logic            in_range;
    logic [ADDR_W-1:0] map_cell, ofs;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign sx       = cur_x_reg[COORD_BITS-1:8];
    assign sy       = cur_y_reg[COORD_BITS-1:8];
    assign mode     = cfg.control[1:0];
    assign size     = cfg.control[3:2];
    assign wrap     = cfg.control[4];

    // layer geometry and texel address
    always_comb
    begin
        if (mode == MODE_BITMAP)
        begin
            wl = 4'd9 + {3'd0, size[0]};
            hl = 4'd10 - {3'd0, size[0]};
        end
        else
        begin
            wl = 4'd7 + {2'd0, size};
            hl = wl;
        end
        mask_w   = 10'((11'd1 << wl) - 11'd1);
        mask_h   = 10'((11'd1 << hl) - 11'd1);
        x        = sx[9:0] & mask_w;
        y        = sy[9:0] & mask_h;
        in_range = wrap || (((sx >> wl) == '0) && ((sy >> hl) == '0));
        map_cell = (ADDR_W'(y[9:3]) << (wl - 4'd3)) + ADDR_W'(x[9:3]);
        ofs      = (ADDR_W'(y) << wl) | ADDR_W'(x);
    end

    always_comb
    begin
        ref_x_next       = ref_x_reg;
        ref_y_next       = ref_y_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        push             = 1'b0;
        push_item.op     = OP_NONE;
        push_item.clear  = (mode == MODE_UNUSED) || !in_range;
        push_item.bitmap = (mode == MODE_BITMAP);
        push_item.map16  = (mode == MODE_MAP16);
        push_item.addr   = ADDR_W'(cfg.map_base)
                         + ((mode == MODE_MAP16) ? (map_cell << 1) : map_cell);
        push_item.col    = x[2:0];
        push_item.row    = y[2:0];
        push_item.data   = write_byte;
        push_item.colour = palette_colour;
        if (mode == MODE_BITMAP)
        begin
            push_item.addr = ofs;
        end
        if (accept)
        begin
            case (kind)
                KIND_PIXEL:
                begin
                    push         = 1'b1;
                    push_item.op = OP_PIXEL;
                    cur_x_next   = cur_x_reg + COORD_BITS'(cfg.pa);
                    cur_y_next   = cur_y_reg + COORD_BITS'(cfg.pc);
                end
                KIND_LINE_END:
                begin
                    ref_x_next = ref_x_reg + COORD_BITS'(cfg.pb);
                    ref_y_next = ref_y_reg + COORD_BITS'(cfg.pd);
                    cur_x_next = ref_x_next;
                    cur_y_next = ref_y_next;
                end
                KIND_LOAD_REF:
                begin
                    ref_x_next = COORD_BITS'(start_x);
                    ref_y_next = COORD_BITS'(start_y);
                    cur_x_next = ref_x_next;
                    cur_y_next = ref_y_next;
                end
                KIND_MEM_WRITE:
                begin
                    push           = 1'b1;
                    push_item.op   = OP_MEM_WR;
                    push_item.addr = ADDR_W'(write_address);
                end
                KIND_PAL_WRITE:
                begin
                    push           = 1'b1;
                    push_item.op   = OP_PAL_WR;
                    push_item.data = palette_slot;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_x_reg <= '0;
            ref_y_reg <= '0;
            cur_x_reg <= '0;
            cur_y_reg <= '0;
        end
        else
        begin
            ref_x_reg <= ref_x_next;
            ref_y_reg <= ref_y_next;
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/abg_fifo.sv */
// ----------------------------------------------------------------------------
// abg_fifo
// short queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

`include "affine_background_pixel_fetch_defines.svh"

module abg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  wire [WIDTH-1:0]  push_data,
    input  wire              pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty,
    output logic             full
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = PW + 1;

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign pop_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ABG_CHECK(a_count_bound, count_reg <= CW'(DEPTH), "queue count beyond depth")
    `ABG_IMPLY(a_no_overflow, push, !full, "push into full queue")
    `ABG_IMPLY(a_no_underflow, pop, !empty, "pop from empty queue")
    `ABG_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1,
        "queue count lost a push")

endmodule

`default_nettype wire

/* hw/rtl/abg_back.sv */
// ----------------------------------------------------------------------------
// abg_back
// fetch pipeline: map read, tile read, palette read into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module abg_back #(
    parameter int AW = 19
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire  [18:0]         tile_base,
    input  wire                 q_empty,
    input  abg_pkg::abg_item_t  head,
    output logic                pop,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic [15:0]         colour,
    output logic                transparent
);
    import abg_pkg::*;

    localparam int BW    = AW - 1;
    localparam int WORDS = 1 << BW;

    logic [7:0]  even_mem [WORDS];
    logic [7:0]  odd_mem  [WORDS];
    logic [15:0] pal_mem  [256];

    logic          adv;
    logic [AW-1:0] ea, ea1;
    logic [BW-1:0] ra_even, ra_odd;
    logic          we_even, we_odd;

    logic          s1_valid_reg;
    abg_item_t     s1_item_reg;
    logic          s1_lsb_reg;
    logic [7:0]    ma_even_reg, ma_odd_reg;

    logic [7:0]    lo, hi;
    logic [9:0]    tile;
    logic [2:0]    col, row;
    logic [AW-1:0] ta;

    logic          s2_valid_reg;
    abg_item_t     s2_item_reg;
    logic          s2_lsb_reg;
    logic [7:0]    s2_lo_reg;
    logic [7:0]    tb_even_reg, tb_odd_reg;

    logic [7:0]    idx;
    logic          clear;

    logic          out_valid_reg;
    logic          out_tr_reg;
    logic [15:0]   pal_rd_reg;

    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && !q_empty;

    // map read addresses, the halfword may straddle the two banks
    always_comb
    begin
        ea      = head.addr[AW-1:0];
        ea1     = ea + 1'b1;
        ra_odd  = ea[AW-1:1];
        ra_even = ea[0] ? ea1[AW-1:1] : ea[AW-1:1];
        we_even = pop && (head.op == OP_MEM_WR) && !ea[0];
        we_odd  = pop && (head.op == OP_MEM_WR) && ea[0];
    end

    // tile address
    always_comb
    begin
        lo   = s1_lsb_reg ? ma_odd_reg : ma_even_reg;
        hi   = s1_lsb_reg ? ma_even_reg : ma_odd_reg;
        tile = s1_item_reg.map16 ? {hi[1:0], lo} : {2'b00, lo};
        col  = s1_item_reg.col ^ {3{s1_item_reg.map16 && hi[2]}};
        row  = s1_item_reg.row ^ {3{s1_item_reg.map16 && hi[3]}};
        ta   = AW'(tile_base) + AW'({tile, row, col});
    end

    always_comb
    begin
        idx   = s2_item_reg.bitmap ? s2_lo_reg : (s2_lsb_reg ? tb_odd_reg : tb_even_reg);
        clear = s2_item_reg.clear || (idx == 8'd0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (we_even)
            begin
                even_mem[ea[AW-1:1]] <= head.data;
            end
            ma_even_reg <= even_mem[ra_even];
            tb_even_reg <= even_mem[ta[AW-1:1]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (we_odd)
            begin
                odd_mem[ea[AW-1:1]] <= head.data;
            end
            ma_odd_reg <= odd_mem[ra_odd];
            tb_odd_reg <= odd_mem[ta[AW-1:1]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (s2_valid_reg && (s2_item_reg.op == OP_PAL_WR))
            begin
                pal_mem[s2_item_reg.data] <= s2_item_reg.colour;
            end
            pal_rd_reg <= pal_mem[idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg <= head;
            s1_lsb_reg  <= ea[0];
            s2_item_reg <= s1_item_reg;
            s2_lsb_reg  <= ta[0];
            s2_lo_reg   <= lo;
            out_tr_reg  <= clear;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= !q_empty;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && (s2_item_reg.op == OP_PIXEL);
        end
    end

    assign out_valid   = out_valid_reg;
    assign transparent = out_tr_reg;
    assign colour      = out_tr_reg ? 16'd0 : pal_rd_reg;

endmodule

`default_nettype wire
